>>> rtl/core/amsc_pkg.sv
// ----------------------------------------------------------------------------
// amsc_pkg
// Types and constants shared by the accelerometer magnitude step counter.
// ----------------------------------------------------------------------------
package amsc_pkg;

    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
    } in_item_t;

    typedef struct packed {
        logic [15:0] magnitude;
        logic        step_seen;
        logic [15:0] step_total;
        logic [27:0] distance_mm;
        logic [16:0] calories;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE,
        ST_PRODUCT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_MM         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MILLICAL_PER_STEP = 2'd2;

    localparam logic [15:0] THRESHOLD_RESET = 16'd492;
    localparam logic [11:0] STRIDE_RESET    = 12'd707;
    localparam logic [9:0]  MILLICAL_RESET  = 10'd40;

    localparam int unsigned MUL_W = 27;

    // floor(p / 1000) == (p * RECIP_1000) >> RECIP_SHIFT for p < 2**26
    localparam logic [MUL_W-1:0] RECIP_1000  = 27'd68719477;
    localparam int unsigned      RECIP_SHIFT = 36;

    localparam int unsigned RADICAND_W = 32;
    localparam int unsigned ROOT_W     = 16;

endpackage

>>> rtl/core/amsc_isqrt.sv
// ----------------------------------------------------------------------------
// amsc_isqrt
// Iterative floor square root, one result bit per cycle (restoring method).
// ----------------------------------------------------------------------------
module amsc_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [amsc_pkg::RADICAND_W-1:0]   radicand,
    output amsc_pkg::sqrt_stat_t              stat,
    output logic [amsc_pkg::ROOT_W-1:0]       root
);
    import amsc_pkg::*;

    localparam int unsigned REM_W = ROOT_W + 1;
    localparam int unsigned CNT_W = $clog2(ROOT_W);

    logic [RADICAND_W-1:0] rad_reg,  rad_next;
    logic [REM_W-1:0]      rem_reg,  rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [REM_W+1:0]      rem_shift;
    logic [REM_W+1:0]      trial;
    logic [REM_W+2:0]      diff;

    assign rem_shift = {rem_reg, rad_reg[RADICAND_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign diff      = {1'b0, rem_shift} - {1'b0, trial};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RADICAND_W-3:0], 2'b00};
            if (!diff[REM_W+2])
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

>>> rtl/core/accel_magnitude_step_counter.sv
// ----------------------------------------------------------------------------
// accel_magnitude_step_counter
// Three-axis magnitude, step detection and distance / calorie totals.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one accelerometer sample per
// request; output channel out_valid/out_ready/out_data returns one result per
// sample. Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce;
// index 0 is the threshold, 1 the stride, 2 the energy per step, other
// indexes are ignored. in_ready is high only while idle. A result is formed
// from the squares on the shared 27x27 multiplier, the 16-step square root,
// the step update and the distance and calorie products on the same
// multiplier, in that order, and is then shown on out_valid. No new request
// is taken until that result is accepted; if the receiver stalls, the result
// holds on out_data.
// Reset clears the step count and previous magnitude and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module accel_magnitude_step_counter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [amsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  amsc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output amsc_pkg::out_item_t                 out_data
);
    import amsc_pkg::*;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic [15:0] u;
        u = v;
        abs16 = v[15] ? 16'(~u + 16'd1) : u;
    endfunction

    state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;

    logic [15:0] thr_reg;
    logic [11:0] stride_reg;
    logic [9:0]  mcal_reg;

    logic [15:0] ax_reg, ay_reg, az_reg;
    logic [RADICAND_W-1:0] sum_reg, sum_next;
    logic [2*MUL_W-1:0] mul_reg;
    logic [MUL_W-1:0] mul_a, mul_b;

    logic [15:0] mag_reg, mag_next;
    logic [15:0] last_reg, last_next;
    logic [15:0] count_reg, count_next;
    logic        seen_reg, seen_next;
    logic [27:0] dist_reg, dist_next;
    logic [16:0] cal_reg, cal_next;
    logic        seen_now;

    logic               sqrt_start;
    sqrt_stat_t         sq_stat;
    logic [ROOT_W-1:0]  sq_root;

    amsc_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                    step_next  = 2'd0;
                end
            end
            ST_SQUARE:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_ROOT;
                    step_next  = 2'd0;
                end
            end
            ST_ROOT:
            begin
                if (step_reg == 2'd0)
                begin
                    step_next = 2'd1;
                end
                else if (sq_stat.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_PRODUCT;
                step_next  = 2'd0;
            end
            ST_PRODUCT:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and multiplier operands
    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SQUARE:
            begin
                case (step_reg)
                    2'd0:    mul_a = MUL_W'(ax_reg);
                    2'd1:    mul_a = MUL_W'(ay_reg);
                    default: mul_a = MUL_W'(az_reg);
                endcase
                mul_b = mul_a;
            end
            ST_ROOT:
            begin
                sqrt_start = (step_reg == 2'd0);
            end
            ST_UPDATE:
            begin
            end
            ST_PRODUCT:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        mul_a = MUL_W'(count_reg);
                        mul_b = MUL_W'(stride_reg);
                    end
                    2'd1:
                    begin
                        mul_a = MUL_W'(count_reg);
                        mul_b = MUL_W'(mcal_reg);
                    end
                    default:
                    begin
                        mul_a = MUL_W'(mul_reg[25:0]);
                        mul_b = RECIP_1000;
                    end
                endcase
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign seen_now = (mag_reg > last_reg) && (16'(mag_reg - last_reg) > thr_reg);

    // datapath next values
    always_comb
    begin
        sum_next   = sum_reg;
        mag_next   = mag_reg;
        last_next  = last_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        dist_next  = dist_reg;
        cal_next   = cal_reg;
        if (state_reg == ST_SQUARE)
        begin
            if (step_reg == 2'd1)
            begin
                sum_next = mul_reg[RADICAND_W-1:0];
            end
            else if (step_reg != 2'd0)
            begin
                sum_next = sum_reg + mul_reg[RADICAND_W-1:0];
            end
        end
        if (state_reg == ST_ROOT && sq_stat.done)
        begin
            mag_next = sq_root;
        end
        if (state_reg == ST_UPDATE)
        begin
            seen_next  = seen_now;
            count_next = count_reg + {15'd0, seen_now};
            last_next  = mag_reg;
        end
        if (state_reg == ST_PRODUCT)
        begin
            if (step_reg == 2'd1)
            begin
                dist_next = mul_reg[27:0];
            end
            if (step_reg == 2'd3)
            begin
                cal_next = mul_reg[RECIP_SHIFT+16:RECIP_SHIFT];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= 2'd0;
            thr_reg    <= THRESHOLD_RESET;
            stride_reg <= STRIDE_RESET;
            mcal_reg   <= MILLICAL_RESET;
            last_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP_THRESHOLD:    thr_reg    <= cfg_wdata;
                    REG_STRIDE_MM:         stride_reg <= cfg_wdata[11:0];
                    REG_MILLICAL_PER_STEP: mcal_reg   <= cfg_wdata[9:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg <= abs16(in_data.acc_x);
            ay_reg <= abs16(in_data.acc_y);
            az_reg <= abs16(in_data.acc_z);
        end
        mul_reg  <= mul_a * mul_b;
        sum_reg  <= sum_next;
        mag_reg  <= mag_next;
        seen_reg <= seen_next;
        dist_reg <= dist_next;
        cal_reg  <= cal_next;
    end

    assign out_data.magnitude   = mag_reg;
    assign out_data.step_seen   = seen_reg;
    assign out_data.step_total  = count_reg;
    assign out_data.distance_mm = dist_reg;
    assign out_data.calories    = cal_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && !out_valid))
        else $error("block not busy after request");

    a_sqrt_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.busy |-> (state_reg == ST_ROOT))
        else $error("square root running outside root phase");

    a_step_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.step_seen) |-> (out_data.magnitude > thr_reg))
        else $error("step flagged without magnitude above threshold");

endmodule

>>> dv/accel_magnitude_step_counter_tb.sv
// ----------------------------------------------------------------------------
// accel_magnitude_step_counter_tb
// Self-checking bench for the accelerometer magnitude step counter. Samples go
// in over a valid/ready channel and each result is checked against an in-bench
// model of the magnitude, step detection and distance/calorie totals. Both
// sides idle and stall at random. The run covers directed edge cases, register
// extremes, back-pressure and long stretches of walking-like and raw samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_magnitude_step_counter_tb;

    import amsc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    // model state
    logic [15:0] thr_q      = THRESHOLD_RESET;
    logic [11:0] stride_q   = STRIDE_RESET;
    logic [9:0]  mcal_q     = MILLICAL_RESET;
    logic [15:0] prev_mag_q = '0;
    logic [15:0] steps_q    = '0;

    out_item_t pending_results[$];

    bit calm      = 1'b0;
    int hold_ask  = 0;
    int hold_left = 0;
    int cycles    = 0;
    int mismatches     = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int steps_flagged  = 0;
    int regs_written   = 0;

    accel_magnitude_step_counter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic longint unsigned axis_abs(input logic signed [15:0] a);
        longint v;
        v = longint'(a);
        return (v < 0) ? -v : v;
    endfunction

    function automatic out_item_t track_step(input in_item_t smp);
        longint unsigned ax, ay, az, sum, trial;
        logic [15:0]     root;
        logic [63:0]     prod;
        int              rise;
        out_item_t       r;
        ax = axis_abs(smp.acc_x);
        ay = axis_abs(smp.acc_y);
        az = axis_abs(smp.acc_z);
        sum = ax * ax + ay * ay + az * az;
        root = '0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = longint'(root | (16'd1 << b));
            if (trial * trial <= sum)
                root = root | (16'd1 << b);
        end
        rise = int'(root) - int'(prev_mag_q);
        r.magnitude = root;
        r.step_seen = (rise > int'(thr_q));
        if (r.step_seen)
            steps_q = steps_q + 16'd1;
        prev_mag_q = root;
        r.step_total = steps_q;
        prod = 64'(steps_q) * 64'(stride_q);
        r.distance_mm = prod[27:0];
        prod = (64'(steps_q) * 64'(mcal_q)) / 64'd1000;
        r.calories = prod[16:0];
        return r;
    endfunction

    function automatic in_item_t mk(input int x, input int y, input int z);
        in_item_t s;
        s.acc_x = x[15:0];
        s.acc_y = y[15:0];
        s.acc_z = z[15:0];
        return s;
    endfunction

    // gait-like sample: about 1 g on z with occasional strong heel strikes
    function automatic in_item_t walk_sample();
        int lift;
        lift = ($urandom_range(99) < 30) ? int'($urandom_range(0, 6000))
                                         : int'($urandom_range(0, 600));
        return mk(int'($urandom_range(0, 1200)) - 600,
                  int'($urandom_range(0, 1200)) - 600,
                  2596 + lift);
    endfunction

    function automatic in_item_t raw_sample();
        return mk(int'($urandom()), int'($urandom()), int'($urandom()));
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks and processes
    // ------------------------------------------------------------------------
    task automatic send_sample(input in_item_t smp);
        if (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(track_step(smp));
        samples_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_STEP_THRESHOLD:    thr_q = val;
            REG_STRIDE_MM:         stride_q = val[11:0];
            REG_MILLICAL_PER_STEP: mcal_q = val[9:0];
            default: ;
        endcase
        regs_written++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         results_seen, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_ask > 0)
        begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: magnitude %0d step_total %0d",
                             out_data.magnitude, out_data.step_total);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("magnitude", 64'(want.magnitude),
                            64'(out_data.magnitude));
                check_field("step_seen", 64'(want.step_seen),
                            64'(out_data.step_seen));
                check_field("step_total", 64'(want.step_total),
                            64'(out_data.step_total));
                check_field("distance_mm", 64'(want.distance_mm),
                            64'(out_data.distance_mm));
                check_field("calories", 64'(want.calories),
                            64'(out_data.calories));
            end
            if (out_data.step_seen === 1'b1)
                steps_flagged++;
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_first_sample_and_threshold();
        send_sample(mk(493, 0, 0));     // first request after reset, just above threshold
        send_sample(mk(985, 0, 0));     // rise equals threshold
        send_sample(mk(1478, 0, 0));    // rise one above threshold
        send_sample(mk(0, 0, 0));       // falling
        send_sample(mk(0, 0, 0));       // equal
        send_sample(mk(0, 0, -493));
        settle();
    endtask

    task automatic test_field_extremes();
        send_sample(mk(-32768, -32768, -32768));
        send_sample(mk(32767, 32767, 32767));
        send_sample(mk(32767, -32768, 0));
        send_sample(mk(0, 32767, 0));
        send_sample(mk(0, 0, -32768));
        send_sample(mk(-1, -1, -1));
        send_sample(mk(1, 0, 0));
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_STEP_THRESHOLD, 16'd0);
        write_reg(REG_STRIDE_MM, 16'hFFFF);         // upper bits dropped
        write_reg(REG_MILLICAL_PER_STEP, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h1234);            // out-of-range index, ignored
        send_sample(mk(0, 0, 0));
        send_sample(mk(0, 0, 1));
        send_sample(mk(0, 1, 1));
        send_sample(mk(2, 0, 0));
        settle();
        write_reg(REG_STEP_THRESHOLD, 16'hFFFF);
        write_reg(REG_STRIDE_MM, 16'd0);
        write_reg(REG_MILLICAL_PER_STEP, 16'd0);
        send_sample(mk(0, 0, 0));
        send_sample(mk(-32768, -32768, -32768));    // largest rise still below threshold
        send_sample(mk(0, 0, 0));
        settle();
    endtask

    task automatic test_backpressure();
        write_reg(REG_STEP_THRESHOLD, THRESHOLD_RESET);
        write_reg(REG_STRIDE_MM, 16'(STRIDE_RESET));
        write_reg(REG_MILLICAL_PER_STEP, 16'(MILLICAL_RESET));
        hold_ask = 300;
        repeat (12) send_sample(walk_sample());
        settle();
        repeat (6) send_sample(walk_sample());
        settle();
    endtask

    task automatic random_config();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            write_reg(REG_STEP_THRESHOLD, 16'd0);
        else if (pick < 15)
            write_reg(REG_STEP_THRESHOLD, 16'hFFFF);
        else if (pick < 25)
            write_reg(REG_STEP_THRESHOLD, 16'($urandom()));
        else
            write_reg(REG_STEP_THRESHOLD, 16'($urandom_range(0, 1500)));
        write_reg(REG_STRIDE_MM, 16'($urandom()));
        write_reg(REG_MILLICAL_PER_STEP, 16'($urandom()));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 16'($urandom()));
    endtask

    task automatic test_random_mix(input int phases, input int per_phase);
        int pick;
        for (int p = 0; p < phases; p++)
        begin
            random_config();
            for (int i = 0; i < per_phase; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    send_sample(walk_sample());
                else if (pick < 95)
                    send_sample(raw_sample());
                else
                    send_sample(mk(0, 0, 0));
            end
            settle();
        end
    endtask

    task automatic test_no_idle_stretch();
        calm = 1'b1;
        random_config();
        repeat (130) send_sample(walk_sample());
        settle();
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample_and_threshold();
        test_field_extremes();
        test_register_extremes();
        test_backpressure();
        test_random_mix(6, 120);
        test_no_idle_stretch();

        settle();
        repeat (30) @(posedge clk);
        $display("summary: %0d samples in, %0d results checked, %0d steps flagged",
                 samples_sent, results_seen, steps_flagged);
        $display("summary: %0d register writes, %0d mismatches, %0d cycles",
                 regs_written, mismatches, cycles);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
